>>> hw/rtl/lfu_cache_lru_tiebreak_top_macros.svh
// Assertion macros for the LFU cache checker.
`ifndef LFU_CACHE_LRU_TIEBREAK_TOP_MACROS_SVH
`define LFU_CACHE_LRU_TIEBREAK_TOP_MACROS_SVH
`define LFU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define LFU_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`endif

>>> hw/rtl/lfu_pkg.sv
// Package with the item and result types of the LFU cache.
`default_nettype none
package lfu_pkg;
  localparam int unsigned CapW = 5;
  localparam logic OpGet = 1'b0;
  localparam logic OpPut = 1'b1;
  typedef struct packed {
    logic               op;
    logic signed [31:0] lookup_key;
    logic signed [31:0] write_value;
  } req_t;
  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
    logic               evicted;
    logic signed [31:0] evicted_key;
  } rsp_t;
  typedef struct packed {
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] count;
    logic [47:0] stamp;
  } entry_t;
endpackage
`default_nettype wire

>>> hw/rtl/lfu_if.sv
// Valid-ready channel interfaces for requests and responses.
`default_nettype none
interface lfu_req_if;
  logic         valid;
  logic         ready;
  lfu_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface lfu_rsp_if;
  logic         valid;
  logic         ready;
  lfu_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/lfu_ram.sv
// Generic single-port-write, one-read RAM with registered read data.
`default_nettype none
module lfu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire                                          clk_i,
  input  wire                                          we_i,
  input  wire [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire [Width-1:0]                              wdata_i,
  input  wire [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                             rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> hw/rtl/lfu_cache_lru_tiebreak_top.sv
// Top level of the LFU cache with LRU tie-breaking.
`default_nettype none
// Fully associative key-value cache with least-frequently-used replacement. Entries live in
// one RAM read one slot per cycle. Each request passes through an accept step in StIdle, a
// scan in StScan that reads every slot and waits out the registered read data, a decide step
// in StDecide that writes the entry back and captures the response, and a wait in StWait that
// sets the output valid once the output register is free, all set by the single RAM read port.
// A new request is taken only when the output register is empty or its response transfers in
// the same cycle.
module lfu_cache_lru_tiebreak_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     cfg_we_i,
  input  wire [lfu_pkg::CapW-1:0] cfg_wdata_i,
  lfu_req_if.sink                 req,
  lfu_rsp_if.source               rsp
);
  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned CmpW = CntW + lfu_pkg::CapW;
  localparam int unsigned EntW = $bits(lfu_pkg::entry_t);

  typedef enum logic [1:0] {StIdle, StScan, StDecide, StWait} state_e;

  state_e                 state_q;
  logic [lfu_pkg::CapW-1:0] cap_q;
  lfu_pkg::req_t          req_q;
  logic [IdxW-1:0]        raddr_q;
  logic [IdxW:0]          rcnt_q;
  logic [IdxW-1:0]        cur_q;
  logic                   cur_v_q;
  logic [CntW-1:0]        fill_q;
  logic [47:0]            clock_q;
  logic                   match_v_q, victim_v_q, free_v_q;
  logic [IdxW-1:0]        match_q, victim_q, free_q;
  lfu_pkg::entry_t        match_e_q, victim_e_q;
  logic [CntW-1:0]        used_q;
  logic                   we;
  logic [IdxW-1:0]        waddr;
  lfu_pkg::entry_t        wdata, rdata;
  logic [EntW-1:0]        rdata_raw;
  logic                   rsp_v_q, rsp_v_d;
  lfu_pkg::rsp_t          rsp_q, rsp_d;
  logic [CntW-1:0]        cap_eff;

  lfu_ram #(.Width(EntW), .Depth(CAPACITY)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr_q),
    .rdata_o(rdata_raw)
  );
  assign rdata = lfu_pkg::entry_t'(rdata_raw);

  assign cap_eff = ({{CntW{1'b0}}, cap_q} > CmpW'(CAPACITY)) ? CntW'(CAPACITY) : CntW'(cap_q);

  assign req.ready = (state_q == StIdle) && (!rsp_v_q || rsp.ready);
  assign rsp.valid = rsp_v_q;
  assign rsp.payload = rsp_q;

  logic          ins;
  logic [IdxW-1:0] slot;
  logic          evict;
  always_comb begin
    we = 1'b0;
    waddr = match_q;
    wdata = match_e_q;
    evict = 1'b0;
    slot = free_q;
    ins = 1'b0;
    rsp_d = '0;
    if (match_v_q && (req_q.op == lfu_pkg::OpPut || req_q.op == lfu_pkg::OpGet)) begin
      we = (req_q.op == lfu_pkg::OpGet) || (cap_eff != '0);
      wdata.count = (match_e_q.count == '1) ? match_e_q.count : match_e_q.count + 32'd1;
      wdata.stamp = clock_q + 48'd1;
      if (req_q.op == lfu_pkg::OpPut) begin
        wdata.value = req_q.write_value;
      end
    end else if (req_q.op == lfu_pkg::OpPut && cap_eff != '0) begin
      evict = (used_q >= cap_eff) && victim_v_q;
      slot = evict ? victim_q : free_q;
      ins = evict || free_v_q;
      we = ins;
      waddr = slot;
      wdata.key = req_q.lookup_key;
      wdata.value = req_q.write_value;
      wdata.count = 32'd1;
      wdata.stamp = clock_q + 48'd1;
    end
    if (match_v_q && (req_q.op == lfu_pkg::OpGet || cap_eff != '0)) begin
      rsp_d.hit = 1'b1;
      rsp_d.read_value = (req_q.op == lfu_pkg::OpGet) ? match_e_q.value : '0;
    end
    if (evict) begin
      rsp_d.evicted = 1'b1;
      rsp_d.evicted_key = victim_e_q.key;
    end
    if (state_q != StDecide) begin
      we = 1'b0;
    end
  end

  always_comb begin
    rsp_v_d = rsp_v_q;
    if (rsp_v_q && rsp.ready) begin
      rsp_v_d = 1'b0;
    end
    if ((state_q == StWait) && (!rsp_v_q || rsp.ready)) begin
      rsp_v_d = 1'b1;
    end
  end

  logic better;
  assign better = !victim_v_q || (rdata.count < victim_e_q.count) ||
                  ((rdata.count == victim_e_q.count) && (rdata.stamp < victim_e_q.stamp));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cap_q <= lfu_pkg::CapW'(16);
      fill_q <= '0;
      clock_q <= '0;
      rsp_v_q <= 1'b0;
      raddr_q <= '0;
      rcnt_q <= '0;
      cur_v_q <= 1'b0;
      match_v_q <= 1'b0;
      victim_v_q <= 1'b0;
      free_v_q <= 1'b0;
      used_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      rsp_v_q <= rsp_v_d;
      unique case (state_q)
        StIdle: begin
          if (req.valid && req.ready) begin
            req_q <= req.payload;
            state_q <= StScan;
            raddr_q <= '0;
            rcnt_q <= '0;
            cur_v_q <= 1'b0;
            match_v_q <= 1'b0;
            victim_v_q <= 1'b0;
            free_v_q <= 1'b0;
            used_q <= '0;
          end
        end
        StScan: begin
          if (cur_v_q) begin
            if (CntW'(cur_q) < fill_q) begin
              used_q <= used_q + CntW'(1);
              if (!match_v_q && rdata.key == req_q.lookup_key) begin
                match_v_q <= 1'b1;
                match_q <= cur_q;
                match_e_q <= rdata;
              end
              if (better) begin
                victim_v_q <= 1'b1;
                victim_q <= cur_q;
                victim_e_q <= rdata;
              end
            end else if (!free_v_q) begin
              free_v_q <= 1'b1;
              free_q <= cur_q;
            end
          end
          if (rcnt_q == (IdxW+1)'(CAPACITY)) begin
            cur_v_q <= 1'b0;
            state_q <= StDecide;
          end else begin
            cur_v_q <= 1'b1;
            cur_q <= raddr_q;
            rcnt_q <= rcnt_q + (IdxW+1)'(1);
            raddr_q <= (rcnt_q == (IdxW+1)'(CAPACITY - 1)) ? '0 : raddr_q + IdxW'(1);
          end
        end
        StDecide: begin
          rsp_q <= rsp_d;
          if (we) begin
            clock_q <= clock_q + 48'd1;
          end
          if (ins && !evict) begin
            fill_q <= fill_q + CntW'(1);
          end
          state_q <= StWait;
        end
        StWait: begin
          if (!rsp_v_q || rsp.ready) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/lfu_checker.sv
// Port-level checker for the LFU cache and its bind statement.
`default_nettype none
`include "lfu_cache_lru_tiebreak_top_macros.svh"
module lfu_checker (
  input wire clk_i,
  input wire rst_ni,
  input wire req_valid,
  input wire req_ready,
  input wire rsp_valid,
  input wire rsp_ready,
  input wire rsp_hit,
  input wire rsp_evicted,
  input wire [31:0] rsp_evicted_key
);
  `LFU_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp_valid && !rsp_ready |=> rsp_valid, "rsp dropped")
  `LFU_ASSERT(a_no_back, clk_i, rst_ni, req_valid && req_ready |=> !req_ready, "ready stuck")
  `LFU_ASSERT(a_ev_key, clk_i, rst_ni, rsp_valid && !rsp_evicted |-> rsp_evicted_key == 0, "key")
  `LFU_ASSERT(a_ev_hit, clk_i, rst_ni, rsp_valid && rsp_evicted |-> !rsp_hit, "evict on hit")
  `LFU_ASSERT_RST(a_rst, clk_i, !rst_ni |-> !rsp_valid, "valid in reset")
endmodule

bind lfu_cache_lru_tiebreak_top lfu_checker u_lfu_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_hit(rsp.payload.hit),
  .rsp_evicted(rsp.payload.evicted), .rsp_evicted_key(rsp.payload.evicted_key)
);
`default_nettype wire

>>> tb/tb_lfu_cache_lru_tiebreak_top.sv
// Self-checking testbench for the LFU cache with LRU tie-breaking.
module tb_lfu_cache_lru_tiebreak_top;

  localparam int unsigned Slots = 16;
  localparam int unsigned StallLimit = 20000;
  localparam int unsigned ExpDepth = 64;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;
  logic cfg_we_i = 1'b0;
  logic [lfu_pkg::CapW-1:0] cfg_wdata_i = '0;

  lfu_req_if req ();
  lfu_rsp_if rsp ();

  always #4 clk_i = ~clk_i;

  lfu_cache_lru_tiebreak_top #(.CAPACITY(Slots)) u_top (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req(req.sink),
    .rsp(rsp.source)
  );

  logic        slot_valid[Slots];
  logic [31:0] slot_key[Slots];
  logic [31:0] slot_value[Slots];
  logic [31:0] slot_count[Slots];
  logic [47:0] slot_stamp[Slots];
  logic [47:0] stamp_clock;
  logic [4:0]  cap_reg;

  lfu_pkg::rsp_t exp_rsp[ExpDepth];
  logic [5:0]  exp_wr = '0;
  logic [5:0]  exp_rd = '0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned mismatches = 0;
  int unsigned checked = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_hits = 0;
  int unsigned n_evicts = 0;
  logic [31:0] key_pool[8];

  function automatic void clear_model();
    for (int i = 0; i < Slots; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_count[i] = '0;
      slot_stamp[i] = '0;
    end
    stamp_clock = '0;
    cap_reg = 5'd16;
  endfunction

  function automatic lfu_pkg::rsp_t predict_access(lfu_pkg::req_t r);
    lfu_pkg::rsp_t o;
    int match;
    int free_slot;
    int victim;
    int used;
    int cap;
    o = '0;
    match = -1;
    free_slot = -1;
    victim = -1;
    used = 0;
    cap = (cap_reg > Slots) ? Slots : cap_reg;
    for (int i = 0; i < Slots; i++) begin
      if (slot_valid[i]) begin
        used++;
        if (match < 0 && slot_key[i] == r.lookup_key) match = i;
        if (victim < 0 || slot_count[i] < slot_count[victim] ||
            (slot_count[i] == slot_count[victim] && slot_stamp[i] < slot_stamp[victim]))
          victim = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (r.op == lfu_pkg::OpGet) begin
      if (match >= 0) begin
        o.hit = 1'b1;
        o.read_value = slot_value[match];
        if (slot_count[match] != 32'hFFFF_FFFF) slot_count[match]++;
        stamp_clock++;
        slot_stamp[match] = stamp_clock;
      end
      return o;
    end
    if (cap == 0) return o;
    if (match >= 0) begin
      o.hit = 1'b1;
      slot_value[match] = r.write_value;
      if (slot_count[match] != 32'hFFFF_FFFF) slot_count[match]++;
      stamp_clock++;
      slot_stamp[match] = stamp_clock;
      return o;
    end
    if (used >= cap && victim >= 0) begin
      o.evicted = 1'b1;
      o.evicted_key = slot_key[victim];
      slot_valid[victim] = 1'b0;
      free_slot = victim;
    end
    if (free_slot >= 0) begin
      slot_valid[free_slot] = 1'b1;
      slot_key[free_slot] = r.lookup_key;
      slot_value[free_slot] = r.write_value;
      slot_count[free_slot] = 32'd1;
      stamp_clock++;
      slot_stamp[free_slot] = stamp_clock;
    end
    return o;
  endfunction

  task automatic send_access(logic op, logic [31:0] key, logic [31:0] value);
    lfu_pkg::req_t r;
    r.op = op;
    r.lookup_key = key;
    r.write_value = value;
    if ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.payload <= r;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    exp_rsp[exp_wr] = predict_access(r);
    exp_wr = exp_wr + 6'd1;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (Slots + 8) @(posedge clk_i);
  endtask

  task automatic set_capacity(logic [4:0] c);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= c;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cap_reg = c;
  endtask

  always @(posedge clk_i) begin
    rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    lfu_pkg::rsp_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response %p", rsp.payload);
      end else begin
        want = exp_rsp[exp_rd];
        exp_rd = exp_rd + 6'd1;
        checked++;
        if (want.hit) n_hits++;
        if (want.evicted) n_evicts++;
        if (rsp.payload.hit !== want.hit || rsp.payload.read_value !== want.read_value ||
            rsp.payload.evicted !== want.evicted ||
            rsp.payload.evicted_key !== want.evicted_key) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p, actual %p", want, rsp.payload);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic test_directed();
    send_access(lfu_pkg::OpGet, 32'h8000_0000, 32'h0);
    send_access(lfu_pkg::OpPut, 32'h8000_0000, 32'h7FFF_FFFF);
    send_access(lfu_pkg::OpPut, 32'h7FFF_FFFF, 32'h8000_0000);
    send_access(lfu_pkg::OpPut, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_access(lfu_pkg::OpPut, 32'h0, 32'h0);
    send_access(lfu_pkg::OpGet, 32'h8000_0000, 32'hFFFF_FFFF);
    send_access(lfu_pkg::OpPut, 32'h7FFF_FFFF, 32'h1234_5678);
    send_access(lfu_pkg::OpGet, 32'h7FFF_FFFF, 32'h0);
    send_access(lfu_pkg::OpGet, 32'h5555_5555, 32'h0);
  endtask

  task automatic test_eviction_ties();
    set_capacity(5'd2);
    send_access(lfu_pkg::OpPut, 32'd1, 32'd10);
    send_access(lfu_pkg::OpPut, 32'd2, 32'd20);
    send_access(lfu_pkg::OpPut, 32'd3, 32'd30);
    send_access(lfu_pkg::OpGet, 32'd3, 32'd0);
    send_access(lfu_pkg::OpPut, 32'd4, 32'd40);
    send_access(lfu_pkg::OpPut, 32'd5, 32'd50);
    set_capacity(5'd1);
    send_access(lfu_pkg::OpPut, 32'd6, 32'd60);
    send_access(lfu_pkg::OpPut, 32'd7, 32'd70);
  endtask

  task automatic test_capacity_extremes();
    set_capacity(5'd0);
    send_access(lfu_pkg::OpPut, 32'd9, 32'd90);
    send_access(lfu_pkg::OpGet, 32'd7, 32'd0);
    send_access(lfu_pkg::OpGet, 32'd9, 32'd0);
    set_capacity(5'd31);
    send_access(lfu_pkg::OpPut, 32'd11, 32'd1);
    send_access(lfu_pkg::OpGet, 32'd11, 32'd0);
  endtask

  task automatic test_random(int unsigned n);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) < 8) k = key_pool[$urandom_range(7)] + $urandom_range(20);
      else k = $urandom;
      send_access(1'($urandom_range(1)), k, $urandom);
      if (i % 60 == 59) begin
        case ($urandom_range(3))
          0: set_capacity(5'($urandom_range(31)));
          1: set_capacity(5'd16);
          default: set_capacity(5'($urandom_range(16, 1)));
        endcase
      end
    end
  endtask

  initial begin
    req.valid = 1'b0;
    req.payload = '0;
    rsp.ready = 1'b0;
    rst_ni <= 1'b0;
    clear_model();
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 22;
    recv_idle_pct = 65;
    test_directed();
    test_eviction_ties();
    test_capacity_extremes();
    set_capacity(5'd16);
    test_random(230);
    drain();
    send_idle_pct = 65;
    recv_idle_pct = 22;
    test_random(230);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(230);
    drain();
    $display("covered %0d checked transfers, %0d hits and %0d evictions",
             checked, n_hits, n_evicts);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
